// ===== rtl/swre_pkg.sv =====
// Shared types, constants and the GF(2^8) multiply for the repair encoder.
`timescale 1ns / 1ps

package swre_pkg;

    // Default sizes for the top-level parameters
    localparam int WINDOW_MAX_DEF = 128;
    localparam int SYMBOL_MAX_DEF = 2048;

    // Fixed field and register widths
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int SYM_REG_W   = 12;
    localparam int WIN_REG_W   = 8;
    localparam int MODE_W      = 2;
    localparam int COEFF_IDX_W = 7;
    localparam int BYTE_IDX_W  = 11;
    localparam int WIN_LEN_W   = 8;

    // Register reset values before clamping
    localparam int SYMBOL_SIZE_RESET = 1024;
    localparam int WINDOW_SIZE_RESET = 128;

    // Field polynomial x^8+x^4+x^3+x^2+1 and the carry-out bit
    localparam logic [8:0] GF_POLY  = 9'h11D;
    localparam logic [8:0] GF_CARRY = 9'h100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEAL   = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_REPAIR = 2'd2
    } t_mode;

    // Shift-and-add multiply, reduce by the field polynomial on each carry
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sh;
        logic [7:0] acc;
        sh  = {1'b0, a};
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ sh[7:0];
            end
            sh = {sh[7:0], 1'b0};
            if ((sh & GF_CARRY) != 9'd0) begin
                sh = sh ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/sliding_window_gf256_repair_encoder_unit.sv =====
// Sliding-window GF(256) repair encoder: symbol ring, coefficient store, repair fold.
`timescale 1ns / 1ps

// Flow: a seal word that closes a symbol passes through S_SEAL (row map
// read-modify-write) before the next word is taken; other seal and coefficient
// words leave the input ready. A repair word holds the input through S_RUN, one
// symbol ring read per held row, then S_DRAIN and S_DONE, or straight to S_DONE
// when the window is empty or the byte position lies past the symbol.
// Throughput: one word at a time; the next word is taken as soon as the
// current one has left the datapath, even while a result waits at the output.
// Reset (synchronous, active low): counters and row map valid bits clear and the spare
// row returns to physical row WINDOW_MAX; the ring and coefficient memories are not cleared.
module sliding_window_gf256_repair_encoder_unit
    import swre_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int SYMBOL_MAX = SYMBOL_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [BYTE_W-1:0]      i_data_byte,
    input  logic                   i_byte_last,
    input  logic [COEFF_IDX_W-1:0] i_coeff_index,
    input  logic [BYTE_W-1:0]      i_coeff_value,
    input  logic [BYTE_IDX_W-1:0]  i_byte_index,
    // result words
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [BYTE_W-1:0]      o_repair_byte,
    output logic [WIN_LEN_W-1:0]   o_held_len,
    output logic                   o_last_byte
);

    // Widths that follow from the parameters
    localparam int PW   = $clog2(SYMBOL_MAX);       // byte position in a row
    localparam int SSW  = $clog2(SYMBOL_MAX + 1);   // symbol size, 1..SYMBOL_MAX
    localparam int RW   = $clog2(WINDOW_MAX);       // logical ring row
    localparam int CNTW = $clog2(WINDOW_MAX + 1);   // held count, 0..WINDOW_MAX
    localparam int PHW  = $clog2(WINDOW_MAX + 1);   // physical row, one spare
    localparam int AW   = PHW + PW;
    localparam int RING_DEPTH = (WINDOW_MAX + 1) * (1 << PW);
    localparam int SS_RESET   = (SYMBOL_SIZE_RESET > SYMBOL_MAX) ? SYMBOL_MAX
                                                                 : SYMBOL_SIZE_RESET;
    localparam int CAP_RESET  = (WINDOW_SIZE_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                 : WINDOW_SIZE_RESET;

    // Row map entry: which physical row backs a logical row, and its sealed length.
    // Bytes at or past the length read as zero, which covers an early last byte.
    typedef struct packed {
        logic [PHW-1:0] phys;
        logic [SSW-1:0] len;
    } t_map_entry;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEAL  = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Clamped configuration
    logic [SSW-1:0]  r_ss;
    logic [CNTW-1:0] r_cap;

    // Window bookkeeping
    logic [RW-1:0]   r_write_row;
    logic [CNTW-1:0] r_held;
    logic [PW-1:0]   r_fill_pos;
    logic [PHW-1:0]  r_spare;      // physical row that takes the symbol being filled
    logic [SSW-1:0]  r_seal_len;
    logic [WINDOW_MAX-1:0] r_map_valid;

    // Repair fold
    logic [BYTE_IDX_W-1:0] r_bi;
    logic [CNTW-1:0]       r_count;
    logic                  r_last;
    logic [RW-1:0]         r_ptr;
    logic [RW-1:0]         r_idx;
    logic [BYTE_W-1:0]     r_acc;
    logic                  r_s1_v;
    logic                  r_s2_v;
    logic                  r_s2_hit;
    logic [BYTE_W-1:0]     r_s2_coeff;

    // Memories and their registered read data
    logic [BYTE_W-1:0] r_ring [0:RING_DEPTH-1];
    t_map_entry        r_map  [0:WINDOW_MAX-1];
    logic [BYTE_W-1:0] r_coeff [0:WINDOW_MAX-1];
    logic [BYTE_W-1:0] r_ring_q;
    t_map_entry        r_map_q;
    logic              r_map_vld_q;
    logic [RW-1:0]     r_map_addr_q;
    logic [BYTE_W-1:0] r_coeff_q;

    // Output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [WIN_LEN_W-1:0] r_out_len;
    logic              r_out_last;

    logic            in_acc;
    t_mode           mode;
    logic [SSW-1:0]  pos_inc;
    logic            seal_now;
    logic            bi_ok;
    logic            bi_last;
    logic [CNTW:0]   wr_ext, cnt_ext, cap_ext, start_sum;
    logic [RW-1:0]   start_row;
    logic [RW-1:0]   ptr_next;
    logic            idx_last;
    logic [RW-1:0]   map_raddr;
    logic [PHW-1:0]  s1_phys;
    logic [SSW-1:0]  s1_len;
    logic            s1_hit;
    logic [AW-1:0]   ring_raddr;
    logic [AW-1:0]   ring_waddr;
    logic            ring_we;
    logic            coeff_we;
    logic [PHW-1:0]  old_phys;
    logic            out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign mode       = t_mode'(i_mode);

    // Seal: the byte at the last position closes the symbol even without byte_last
    assign pos_inc  = SSW'(r_fill_pos) + SSW'(1);
    assign seal_now = i_byte_last || (pos_inc == r_ss);

    // Repair request checks against the current symbol size
    assign bi_ok   = 32'(i_byte_index) < 32'(r_ss);
    assign bi_last = (32'(i_byte_index) + 32'd1) == 32'(r_ss);

    // Oldest held row: write_row minus held count, modulo the window
    assign wr_ext    = (CNTW + 1)'(r_write_row);
    assign cnt_ext   = (CNTW + 1)'(r_held);
    assign cap_ext   = (CNTW + 1)'(r_cap);
    assign start_sum = (wr_ext >= cnt_ext) ? (wr_ext - cnt_ext)
                                           : (wr_ext + cap_ext - cnt_ext);
    assign start_row = RW'(start_sum);

    assign ptr_next = ((CNTW'(r_ptr) + CNTW'(1)) == r_cap) ? '0 : (r_ptr + RW'(1));
    assign idx_last = (CNTW'(r_idx) + CNTW'(1)) == r_count;

    // Row map port: walk the window while folding, else look at the write row
    assign map_raddr = (r_state == S_RUN) ? r_ptr : r_write_row;

    // Stage 1: resolve the physical row; an entry never written maps to itself
    assign s1_phys    = r_map_vld_q ? r_map_q.phys : PHW'(r_map_addr_q);
    assign s1_len     = r_map_vld_q ? r_map_q.len  : '0;
    assign s1_hit     = 32'(r_bi) < 32'(s1_len);
    assign ring_raddr = {s1_phys, PW'(r_bi)};

    // Fill bytes go straight into the spare row, hidden until sealed
    assign ring_we    = in_acc && (mode == MODE_SEAL);
    assign ring_waddr = {r_spare, r_fill_pos};
    assign coeff_we   = in_acc && (mode == MODE_LOAD)
                        && (32'(i_coeff_index) < WINDOW_MAX);

    // The row that leaves the window becomes the next spare
    assign old_phys = r_map_vld_q ? r_map_q.phys : PHW'(r_map_addr_q);

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (mode)
                        MODE_SEAL: begin
                            if (seal_now) begin
                                n_state = S_SEAL;
                            end
                        end
                        MODE_REPAIR: begin
                            if (bi_ok && (r_held != '0)) begin
                                n_state = S_RUN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEAL: n_state = S_IDLE;
            S_RUN: begin
                if (idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memories: one write and one registered read each cycle
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= i_data_byte;
        end
        r_ring_q <= r_ring[ring_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEAL) begin
            r_map[r_write_row] <= '{phys: r_spare, len: r_seal_len};
        end
        r_map_q      <= r_map[map_raddr];
        r_map_vld_q  <= r_map_valid[map_raddr];
        r_map_addr_q <= map_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (coeff_we) begin
            r_coeff[RW'(i_coeff_index)] <= i_coeff_value;
        end
        r_coeff_q <= r_coeff[r_idx];
    end

    // Control and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ss        <= SSW'(SS_RESET);
            r_cap       <= CNTW'(CAP_RESET);
            r_write_row <= '0;
            r_held      <= '0;
            r_fill_pos  <= '0;
            r_spare     <= PHW'(WINDOW_MAX);
            r_map_valid <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
        end else begin
            r_state <= n_state;

            // Any register write restarts the window and drops a partial symbol
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SYMBOL_SIZE: begin
                        if (i_cfg_data[SYM_REG_W-1:0] == '0) begin
                            r_ss <= SSW'(1);
                        end else if (int'(i_cfg_data[SYM_REG_W-1:0]) > SYMBOL_MAX) begin
                            r_ss <= SSW'(SYMBOL_MAX);
                        end else begin
                            r_ss <= SSW'(i_cfg_data[SYM_REG_W-1:0]);
                        end
                    end
                    REG_WINDOW_SIZE: begin
                        if (i_cfg_data[WIN_REG_W-1:0] == '0) begin
                            r_cap <= CNTW'(1);
                        end else if (int'(i_cfg_data[WIN_REG_W-1:0]) > WINDOW_MAX) begin
                            r_cap <= CNTW'(WINDOW_MAX);
                        end else begin
                            r_cap <= CNTW'(i_cfg_data[WIN_REG_W-1:0]);
                        end
                    end
                    default: ;
                endcase
                r_write_row <= '0;
                r_held      <= '0;
                r_fill_pos  <= '0;
            end

            // Advance the fill position, or hold the sealed length for the map write
            if (ring_we) begin
                if (seal_now) begin
                    r_seal_len <= pos_inc;
                end else begin
                    r_fill_pos <= PW'(pos_inc);
                end
            end

            // Seal: swap the spare into the ring, retire the overwritten row
            if (r_state == S_SEAL) begin
                r_map_valid[r_write_row] <= 1'b1;
                r_spare     <= old_phys;
                r_write_row <= ((CNTW'(r_write_row) + CNTW'(1)) == r_cap)
                               ? '0 : (r_write_row + RW'(1));
                if (r_held < r_cap) begin
                    r_held <= r_held + CNTW'(1);
                end
                r_fill_pos <= '0;
            end

            r_s1_v <= (r_state == S_RUN);
            r_s2_v <= r_s1_v;
        end
    end

    // Repair fold datapath
    always_ff @(posedge i_clk) begin
        if (in_acc && (mode == MODE_REPAIR)) begin
            r_bi    <= i_byte_index;
            r_count <= r_held;
            r_last  <= bi_ok && bi_last;
            r_ptr   <= start_row;
            r_idx   <= '0;
            r_acc   <= '0;
        end
        if (r_state == S_RUN) begin
            r_ptr <= ptr_next;
            r_idx <= r_idx + RW'(1);
        end
        // stage 2 gets the registered ring byte in the cycle after its address
        r_s2_hit   <= s1_hit;
        r_s2_coeff <= r_coeff_q;
        if (r_s2_v && r_s2_hit) begin
            r_acc <= r_acc ^ gf_mul(r_s2_coeff, r_ring_q);
        end
    end

    // Output register: load when free or being taken, drop on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_acc;
            r_out_len  <= WIN_LEN_W'(r_count);
            r_out_last <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_repair_byte = r_out_byte;
    assign o_held_len    = r_out_len;
    assign o_last_byte   = r_out_last;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sliding-window GF(256) repair encoder unit.
`timescale 1ns / 1ps

module tb;
    import swre_pkg::*;

    // Sizes of the block as built, and the run's timing knobs
    localparam int  ROWS         = WINDOW_MAX_DEF;
    localparam int  COLS         = SYMBOL_MAX_DEF;
    localparam int  SETTLE_CYCLES = ROWS + 24;   // longest repair fold plus margin
    localparam int  LONG_STALL   = 2500;
    localparam time RUN_LIMIT    = 64'd20_000_000;

    // Mode 3 has no meaning in the block and must be dropped silently
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // One input word, with every field on its own port
    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [BYTE_W-1:0]      data_byte;
        logic                   byte_last;
        logic [COEFF_IDX_W-1:0] coeff_index;
        logic [BYTE_W-1:0]      coeff_value;
        logic [BYTE_IDX_W-1:0]  byte_index;
    } t_word;

    // One repair result
    typedef struct packed {
        logic [BYTE_W-1:0]    repair_byte;
        logic [WIN_LEN_W-1:0] held_len;
        logic                 last_byte;
    } t_repair;

    // Clock, reset and every block input start at known values
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      in_mode = '0;
    logic [BYTE_W-1:0]      in_data_byte = '0;
    logic                   in_byte_last = 1'b0;
    logic [COEFF_IDX_W-1:0] in_coeff_index = '0;
    logic [BYTE_W-1:0]      in_coeff_value = '0;
    logic [BYTE_IDX_W-1:0]  in_byte_index = '0;
    logic                   o_out_valid;
    logic                   out_ready = 1'b0;
    logic [BYTE_W-1:0]      o_repair_byte;
    logic [WIN_LEN_W-1:0]   o_held_len;
    logic                   o_last_byte;

    sliding_window_gf256_repair_encoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (in_mode),
        .i_data_byte   (in_data_byte),
        .i_byte_last   (in_byte_last),
        .i_coeff_index (in_coeff_index),
        .i_coeff_value (in_coeff_value),
        .i_byte_index  (in_byte_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_repair_byte (o_repair_byte),
        .o_held_len    (o_held_len),
        .o_last_byte   (o_last_byte)
    );

    // Words waiting to be offered, and repairs waiting to come out
    t_word   pending_words[$];
    t_repair expected_repairs[$];
    t_word   bus_word;
    int      words_queued = 0;
    int      words_taken = 0;
    int      mismatches = 0;

    // Idle and stall rates in percent, set per phase while the block is quiet
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off, armed once by the stimulus
    bit   stall_arm = 1'b0;
    logic stall_on = 1'b0;

    // Shadow of the encoder: staged symbol, sealed rows, coefficients, counters
    logic [7:0]  ring_mem [ROWS][COLS];
    logic [7:0]  stage_mem [COLS];
    logic [7:0]  coeff_mem [ROWS];
    int unsigned sym_reg = SYMBOL_SIZE_RESET;
    int unsigned win_reg = WINDOW_SIZE_RESET;
    int unsigned next_row = 0;
    int unsigned rows_held = 0;
    int unsigned fill_at = 0;

    // 20 ns clock
    initial begin : clock_gen
        forever #10 i_clk = ~i_clk;
    end

    initial begin : stage_clear
        for (int j = 0; j < COLS; j++) stage_mem[j] = 8'd0;
    end

    // Zero counts as one, anything above the build size counts as the build size
    function automatic int unsigned eff_symbol();
        if (sym_reg == 0) return 1;
        return (sym_reg > COLS) ? COLS : sym_reg;
    endfunction

    function automatic int unsigned eff_window();
        if (win_reg == 0) return 1;
        return (win_reg > ROWS) ? ROWS : win_reg;
    endfunction

    // GF(2^8) product, Horner form from the top bit of b down
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        int         k;
        p = 8'd0;
        for (k = 7; k >= 0; k--) begin
            p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY[7:0] : 8'd0);
            if (b[k]) p = p ^ a;
        end
        return p;
    endfunction

    // Advance the shadow by one accepted word; queue the repair it causes
    task automatic absorb_word(input t_word w);
        int unsigned ss;
        int unsigned cap;
        int unsigned pos;
        int unsigned row;
        int unsigned cnt;
        int unsigned first;
        logic [7:0]  acc;
        t_repair     res;
        ss  = eff_symbol();
        cap = eff_window();
        case (w.mode)
            MODE_SEAL: begin
                pos = (fill_at < ss) ? fill_at : ss - 1;
                stage_mem[pos] = w.data_byte;
                if (w.byte_last || pos + 1 >= ss) begin
                    // seal: copy the staged bytes, zero the tail of the row
                    row = next_row % cap;
                    for (int j = 0; j < ss; j++) begin
                        ring_mem[row][j] = (j <= pos) ? stage_mem[j] : 8'd0;
                        stage_mem[j] = 8'd0;
                    end
                    next_row = (row + 1) % cap;
                    if (rows_held < cap) rows_held++;
                    fill_at = 0;
                end else begin
                    fill_at = pos + 1;
                end
            end
            MODE_LOAD: begin
                coeff_mem[w.coeff_index] = w.coeff_value;
            end
            MODE_REPAIR: begin
                cnt   = (rows_held < cap) ? rows_held : cap;
                first = (next_row % cap + cap - cnt) % cap;
                acc   = 8'd0;
                // fold the held rows oldest first; past the symbol end gives zero
                if (w.byte_index < ss) begin
                    for (int i = 0; i < cnt; i++) begin
                        acc = acc ^ gf_times(coeff_mem[i],
                                             ring_mem[(first + i) % cap][w.byte_index]);
                    end
                end
                res.repair_byte = acc;
                res.held_len    = cnt[WIN_LEN_W-1:0];
                res.last_byte   = (w.byte_index < ss) && (w.byte_index + 1 == ss);
                expected_repairs = {expected_repairs, res};
            end
            default: begin
                // spare mode: drop
            end
        endcase
    endtask

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Driver: offer the next word when the bus is free, hold it until taken
    always @(posedge i_clk) begin : drive_words
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                absorb_word(bus_word);
                words_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_words.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    bus_word = pending_words[0];
                    pending_words.delete(0);
                    in_valid       <= 1'b1;
                    in_mode        <= bus_word.mode;
                    in_data_byte   <= bus_word.data_byte;
                    in_byte_last   <= bus_word.byte_last;
                    in_coeff_index <= bus_word.coeff_index;
                    in_coeff_value <= bus_word.coeff_value;
                    in_byte_index  <= bus_word.byte_index;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, or a hard hold-off while the long stall runs
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n || stall_on) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Hold the receiver off for a long stretch so the block backs up into its input
    initial begin : long_stall
        wait (stall_arm);
        @(posedge i_clk);
        stall_on <= 1'b1;
        repeat (LONG_STALL) @(posedge i_clk);
        stall_on <= 1'b0;
    end

    // Monitor: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_repair want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_repairs.size() == 0) begin
                note_mismatch($sformatf("repair word with none expected (byte %0h len %0d)",
                                        o_repair_byte, o_held_len));
            end else begin
                want = expected_repairs[0];
                expected_repairs.delete(0);
                if (o_repair_byte !== want.repair_byte)
                    note_mismatch($sformatf("repair_byte %0h, want %0h",
                                            o_repair_byte, want.repair_byte));
                if (o_held_len !== want.held_len)
                    note_mismatch($sformatf("held_len %0d, want %0d",
                                            o_held_len, want.held_len));
                if (o_last_byte !== want.last_byte)
                    note_mismatch($sformatf("last_byte %0b, want %0b",
                                            o_last_byte, want.last_byte));
            end
        end
    end

    function automatic t_word make_word(input logic [MODE_W-1:0] mode,
                                        input logic [7:0] data, input logic last,
                                        input logic [6:0] ci, input logic [7:0] cv,
                                        input logic [10:0] bi);
        t_word w;
        w.mode        = mode;
        w.data_byte   = data;
        w.byte_last   = last;
        w.coeff_index = ci;
        w.coeff_value = cv;
        w.byte_index  = bi;
        return w;
    endfunction

    // Random word: all fields random, mode and byte position biased by the phase
    function automatic t_word rand_word(input int seal_pct, input int last_pct,
                                        input int repair_pct);
        t_word       w;
        int          pick;
        int unsigned ss;
        ss   = eff_symbol();
        pick = $urandom_range(0, 99);
        w.data_byte   = 8'($urandom_range(0, 255));
        w.coeff_index = 7'($urandom_range(0, 127));
        w.coeff_value = 8'($urandom_range(0, 255));
        w.byte_last   = ($urandom_range(0, 99) < last_pct);
        case ($urandom_range(0, 9))
            0:       w.byte_index = 11'($urandom_range(0, 2047));
            1:       w.byte_index = 11'(ss - 1);
            default: w.byte_index = 11'($urandom_range(0, ss - 1));
        endcase
        if (pick < seal_pct)
            w.mode = MODE_SEAL;
        else if (pick < seal_pct + repair_pct)
            w.mode = MODE_REPAIR;
        else if (pick < 97)
            w.mode = MODE_LOAD;
        else
            w.mode = MODE_SPARE;
        return w;
    endfunction

    task automatic queue_word(input t_word w);
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // Write one register; the shadow restarts its window the same way
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_SYMBOL_SIZE)
            sym_reg = 32'(val);
        else
            win_reg = 32'(val[WIN_REG_W-1:0]);
        next_row  = 0;
        rows_held = 0;
        fill_at   = 0;
        for (int j = 0; j < COLS; j++) stage_mem[j] = 8'd0;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every queued word to be taken and every repair to come out,
    // then let a closing seal finish inside the block
    task automatic drain();
        while (words_taken != words_queued || expected_repairs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] sym,
                             input logic [CFG_DATA_W-1:0] win,
                             input int idle, input int stall, input int count,
                             input int seal_pct, input int last_pct, input int repair_pct,
                             input bit pressure);
        write_reg(REG_SYMBOL_SIZE, sym);
        write_reg(REG_WINDOW_SIZE, win);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (pressure) stall_arm = 1'b1;
        for (int n = 0; n < count; n++) queue_word(rand_word(seal_pct, last_pct, repair_pct));
        drain();
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every coefficient once so no repair can touch an unloaded one
        for (int k = 0; k < ROWS; k++) begin
            queue_word(make_word(MODE_LOAD, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 7'(k),
                                 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047))));
        end

        // Directed part, at the reset sizes (1024 bytes, 128 rows)
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd0));     // empty window
        queue_word(make_word(MODE_SEAL,   8'hFF, 1'b0, 7'd0, 8'h00, 11'd0));     // partial symbol
        queue_word(make_word(MODE_SEAL,   8'h00, 1'b0, 7'd0, 8'h00, 11'd0));
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd0));     // must not see it
        queue_word(make_word(MODE_SEAL,   8'hA5, 1'b1, 7'd0, 8'h00, 11'd0));     // early last byte
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd0));
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd2));
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd1023));  // zero tail, last
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd1024));  // past the end
        queue_word(make_word(MODE_REPAIR, 8'hFF, 1'b1, 7'h7F, 8'hFF, 11'd2047));
        queue_word(make_word(MODE_LOAD,   8'h00, 1'b0, 7'd0, 8'hFF, 11'd0));
        queue_word(make_word(MODE_LOAD,   8'hFF, 1'b1, 7'h7F, 8'h00, 11'h7FF));  // last coefficient index
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd0));
        queue_word(make_word(MODE_SPARE,  8'hFF, 1'b1, 7'h7F, 8'hFF, 11'h7FF));  // dropped
        queue_word(make_word(MODE_SEAL,   8'h3C, 1'b1, 7'd0, 8'h00, 11'd0));
        queue_word(make_word(MODE_LOAD,   8'h00, 1'b0, 7'd1, 8'h01, 11'd0));
        queue_word(make_word(MODE_REPAIR, 8'h00, 1'b0, 7'd0, 8'h00, 11'd0));
        queue_word(make_word(MODE_SEAL,   8'h77, 1'b0, 7'd0, 8'h00, 11'd0));     // left partial
        queue_word(make_word(MODE_SEAL,   8'h88, 1'b0, 7'd0, 8'h00, 11'd0));
        drain();

        // Random phases; each restarts the window through the register writes
        run_phase(12'd3,    12'd4,   0,  0,  40, 50, 25, 35, 1'b0);  // no idling
        run_phase(12'd1,    12'd255, 63, 0,  90, 70, 50, 22, 1'b0);  // window above build size
        run_phase(12'd0,    12'd0,   0,  63, 40, 45, 30, 40, 1'b0);  // zero sizes clamp to one
        run_phase(12'hFFF,  12'd2,   30, 30, 30, 55, 70, 35, 1'b0);  // top symbol size
        run_phase(12'd17,   12'd9,   0,  0,  70, 40, 10, 50, 1'b1);  // long output hold-off
        run_phase(12'd2048, 12'hF80, 30, 30, 40, 55, 60, 35, 1'b0);  // exact maxima

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
